// File: rtl/uwlvh_pkg.sv
// ----------------------------------------------------------------------------
// uwlvh_pkg
// shared types, codes and character helpers of the word length histogram
// ----------------------------------------------------------------------------
package uwlvh_pkg;

   // operation codes on the request channel
   typedef enum logic [1:0] {
      OP_PUSH  = 2'd0,
      OP_READ  = 2'd1,
      OP_CLEAR = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   // utf-8 decode phase
   typedef enum logic [1:0] {
      PH_IDLE  = 2'd0,
      PH_LATIN = 2'd1,
      PH_MID   = 2'd2,
      PH_LAST  = 2'd3
   } phase_type;

   localparam logic [7:0] LATIN_LEAD = 8'hC3;
   localparam logic [7:0] ASCII_TOP  = 8'h80;
   localparam logic [7:0] LEAD3_MIN  = 8'hE0;
   localparam logic [7:0] LEAD4_MIN  = 8'hF0;
   localparam logic [7:0] LEAD4_MAX  = 8'hF7;
   localparam logic [7:0] CASE_GAP   = 8'h20;

   localparam int unsigned COUNT_W = 32;

   function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
      logic [COUNT_W-1:0] r;
      r = (v == '1) ? v : v + COUNT_W'(1);
      return r;
   endfunction

   // final byte of a 3-byte punctuation sequence
   function automatic logic [7:0] map_three_byte(input logic [7:0] b);
      logic [7:0] r;
      case (b) inside
         8'h93:          r = 8'h2D;
         8'h98, 8'h99:   r = 8'h27;
         8'h9C, 8'h9D:   r = 8'h22;
         8'hA6:          r = 8'h2E;
         default:        r = b;
      endcase
      return r;
   endfunction

   // byte after 0xc3: accented letters folded to uppercase ascii, others raw
   function automatic logic [7:0] map_latin(input logic [7:0] b);
      logic [7:0] r;
      case (b) inside
         [8'h80:8'h83], [8'hA0:8'hA3]: r = 8'h41;
         [8'h88:8'h8A], [8'hA8:8'hAA]: r = 8'h45;
         [8'h8C:8'h8D], [8'hAC:8'hAD]: r = 8'h49;
         [8'h92:8'h95], [8'hB2:8'hB5]: r = 8'h4F;
         [8'h99:8'h9A], [8'hB9:8'hBA]: r = 8'h55;
         8'h87, 8'hA7:                 r = 8'h43;
         default:                      r = b;
      endcase
      return r;
   endfunction

   function automatic logic is_separator(input logic [7:0] x);
      logic r;
      case (x) inside
         8'h09, 8'h0A, 8'h0D, 8'h20, 8'h21, 8'h22, 8'h28, 8'h29,
         8'h2C, 8'h2D, 8'h2E, 8'h3A, 8'h3B, 8'h3F, 8'h5B, 8'h5D: r = 1'b1;
         default:                                                r = 1'b0;
      endcase
      return r;
   endfunction

   function automatic logic is_word_char(input logic [7:0] x);
      logic r;
      case (x) inside
         [8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A], 8'h5F: r = 1'b1;
         default:                                           r = 1'b0;
      endcase
      return r;
   endfunction

   function automatic logic is_vowel(input logic [7:0] x);
      logic [7:0] u;
      logic       r;
      u = (x inside {[8'h61:8'h7A]}) ? x - CASE_GAP : x;
      case (u) inside
         8'h41, 8'h45, 8'h49, 8'h4F, 8'h55: r = 1'b1;
         default:                           r = 1'b0;
      endcase
      return r;
   endfunction

endpackage

// File: rtl/uwlvh_ram.sv
// ----------------------------------------------------------------------------
// uwlvh_ram
// single write port, single read port memory with registered read data
// ----------------------------------------------------------------------------
module uwlvh_ram #(
   parameter int unsigned AW = 6,
   parameter int unsigned DW = 32
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [DW-1:0] wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [DW-1:0] rd_data
);

   logic [DW-1:0] mem [2**AW];
   logic [DW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read during write returns the old contents
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/uwlvh_front.sv
// ----------------------------------------------------------------------------
// uwlvh_front
// utf-8 decode, character classify and open word / running totals
// ----------------------------------------------------------------------------
module uwlvh_front #(
   parameter int unsigned LENGTH_BINS = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  uwlvh_pkg::op_type             operation,
   input  logic [7:0]                    data_byte,
   output logic                          close,
   output logic [$clog2(LENGTH_BINS)-1:0] close_length,
   output logic [$clog2(LENGTH_BINS)-1:0] close_vowels,
   output logic [uwlvh_pkg::COUNT_W-1:0] total_next,
   output logic [$clog2(LENGTH_BINS)-1:0] longest_next
);

   import uwlvh_pkg::*;

   localparam int unsigned LW = $clog2(LENGTH_BINS);
   localparam logic [LW-1:0] CHAR_MAX = LW'(LENGTH_BINS - 1);

   phase_type      phase_ff, phase_in;
   logic [LW-1:0]  chars_ff, chars_in;
   logic [LW-1:0]  vowels_ff, vowels_in;
   logic [COUNT_W-1:0] total_ff;
   logic [LW-1:0]  longest_ff;

   logic       push;
   logic       have;
   logic [7:0] ch;
   logic       sep;
   logic       extend;

   assign push = accept && (operation == OP_PUSH);

   // next decode phase
   always_comb begin
      phase_in = phase_ff;
      if (push) begin
         case (phase_ff)
            PH_LATIN: phase_in = PH_IDLE;
            PH_MID:   phase_in = PH_LAST;
            PH_LAST:  phase_in = PH_IDLE;
            PH_IDLE: begin
               if (data_byte == LATIN_LEAD) begin
                  phase_in = PH_LATIN;
               end else if (data_byte >= LEAD4_MIN && data_byte <= LEAD4_MAX) begin
                  phase_in = PH_IDLE;
               end else if (data_byte >= LEAD3_MIN) begin
                  phase_in = PH_MID;
               end
            end
            default:  phase_in = PH_IDLE;
         endcase
      end
   end

   // character produced by this byte
   always_comb begin
      have = 1'b0;
      ch   = data_byte;
      case (phase_ff)
         PH_LATIN: begin
            have = 1'b1;
            ch   = map_latin(data_byte);
         end
         PH_LAST: begin
            have = 1'b1;
            ch   = map_three_byte(data_byte);
         end
         PH_IDLE: begin
            have = (data_byte < ASCII_TOP);
         end
         default: have = 1'b0;
      endcase
   end

   assign sep    = have && is_separator(ch);
   assign close  = push && sep && (chars_ff != '0);
   assign extend = push && have && !sep && is_word_char(ch) && (chars_ff != CHAR_MAX);

   always_comb begin
      chars_in  = chars_ff;
      vowels_in = vowels_ff;
      if (close) begin
         chars_in  = '0;
         vowels_in = '0;
      end else if (extend) begin
         chars_in = chars_ff + LW'(1);
         if (is_vowel(ch)) begin
            vowels_in = vowels_ff + LW'(1);
         end
      end
   end

   always_comb begin
      total_next   = total_ff;
      longest_next = longest_ff;
      if (accept && operation == OP_CLEAR) begin
         total_next   = '0;
         longest_next = '0;
      end else if (close) begin
         total_next = sat_inc(total_ff);
         if (chars_ff > longest_ff) begin
            longest_next = chars_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         chars_ff   <= '0;
         vowels_ff  <= '0;
         total_ff   <= '0;
         longest_ff <= '0;
      end else begin
         phase_ff   <= phase_in;
         chars_ff   <= chars_in;
         vowels_ff  <= vowels_in;
         total_ff   <= total_next;
         longest_ff <= longest_next;
      end
   end

   assign close_length = chars_ff;
   assign close_vowels = vowels_ff;

endmodule

// File: rtl/utf8_word_length_vowel_histogram_core.sv
// ----------------------------------------------------------------------------
// utf8_word_length_vowel_histogram_core
// utf-8 text word length and vowel histogram with read and clear access
// ----------------------------------------------------------------------------
// pipeline: an accepted word is registered in the execute stage, then in the
//    response register; throughput: one word per cycle when the response side
//    does not stall, set by the read-modify-write of the histogram memories,
//    with a write-to-read bypass for back-to-back hits; reset and clear both
//    start a sweep over every address that zeroes the memories; req_ready is low meanwhile
// ----------------------------------------------------------------------------
module utf8_word_length_vowel_histogram_core #(
   parameter int unsigned LENGTH_BINS = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_operation,
   input  logic [7:0]  req_data_byte,
   input  logic [5:0]  req_read_length,
   input  logic [5:0]  req_read_vowels,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_word_closed,
   output logic [5:0]  rsp_closed_length,
   output logic [5:0]  rsp_closed_vowels,
   output logic [31:0] rsp_total_words,
   output logic [5:0]  rsp_longest_word,
   output logic [31:0] rsp_length_count,
   output logic [31:0] rsp_joint_count
);

   import uwlvh_pkg::*;

   localparam int unsigned LW = $clog2(LENGTH_BINS);
   localparam int unsigned JW = 2 * LW;

   // ------------------------------------------------------------------
   // request side
   // ------------------------------------------------------------------
   logic   req_accept;
   op_type req_op;

   assign req_op     = op_type'(req_operation);
   assign req_accept = req_valid && req_ready;

   logic               fr_close;
   logic [LW-1:0]      fr_length;
   logic [LW-1:0]      fr_vowels;
   logic [COUNT_W-1:0] fr_total;
   logic [LW-1:0]      fr_longest;

   // decode and open word tracking, updated right at accept
   uwlvh_front #(
      .LENGTH_BINS (LENGTH_BINS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .accept       (req_accept),
      .operation    (req_op),
      .data_byte    (req_data_byte),
      .close        (fr_close),
      .close_length (fr_length),
      .close_vowels (fr_vowels),
      .total_next   (fr_total),
      .longest_next (fr_longest)
   );

   // read bins, with range checks for narrow configurations
   logic [LW-1:0] rl_addr;
   logic [LW-1:0] rv_addr;
   logic          rl_ok;
   logic          rv_ok;

   assign rl_addr = LW'(req_read_length);
   assign rv_addr = LW'(req_read_vowels);
   assign rl_ok   = (32'(req_read_length) < LENGTH_BINS);
   assign rv_ok   = (32'(req_read_vowels) < LENGTH_BINS);

   // a read op addresses the requested bin, anything else the closing word
   logic [LW-1:0] len_rd_addr;
   logic [JW-1:0] joint_rd_addr;

   always_comb begin
      if (req_op == OP_READ) begin
         len_rd_addr   = rl_addr;
         joint_rd_addr = {rv_addr, rl_addr};
      end else begin
         len_rd_addr   = fr_length;
         joint_rd_addr = {fr_vowels, fr_length};
      end
   end

   // ------------------------------------------------------------------
   // clearing sweep
   // ------------------------------------------------------------------
   logic          sweep_ff, sweep_in;
   logic [JW-1:0] sweep_addr_ff, sweep_addr_in;

   always_comb begin
      sweep_in      = sweep_ff;
      sweep_addr_in = sweep_addr_ff;
      if (req_accept && req_op == OP_CLEAR) begin
         sweep_in      = 1'b1;
         sweep_addr_in = '0;
      end else if (sweep_ff) begin
         sweep_addr_in = sweep_addr_ff + JW'(1);
         if (sweep_addr_ff == '1) begin
            sweep_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_ff      <= 1'b1;
         sweep_addr_ff <= '0;
      end else begin
         sweep_ff      <= sweep_in;
         sweep_addr_ff <= sweep_addr_in;
      end
   end

   // ------------------------------------------------------------------
   // execute stage: read data arrives, increment and write back
   // ------------------------------------------------------------------
   logic               s1_valid_ff, s1_valid_in;
   op_type             s1_op_ff;
   logic               s1_close_ff;
   logic [LW-1:0]      s1_length_ff;
   logic [LW-1:0]      s1_vowels_ff;
   logic [COUNT_W-1:0] s1_total_ff;
   logic [LW-1:0]      s1_longest_ff;
   logic               s1_rl_ok_ff;
   logic               s1_rv_ok_ff;
   logic [LW-1:0]      s1_len_addr_ff;
   logic [JW-1:0]      s1_joint_addr_ff;
   logic               s1_advance;
   logic               s1_wr_en;

   // bypass for a read that lands on the edge of a write to the same entry
   logic               byp_len_hit_ff;
   logic [COUNT_W-1:0] byp_len_data_ff;
   logic               byp_joint_hit_ff;
   logic [COUNT_W-1:0] byp_joint_data_ff;

   logic [COUNT_W-1:0] len_rd_data;
   logic [COUNT_W-1:0] joint_rd_data;
   logic [COUNT_W-1:0] len_cur;
   logic [COUNT_W-1:0] joint_cur;
   logic [COUNT_W-1:0] len_new;
   logic [COUNT_W-1:0] joint_new;

   logic               out_valid_ff, out_valid_in;

   assign s1_advance = !out_valid_ff || rsp_ready;
   assign req_ready  = !sweep_ff && (!s1_valid_ff || s1_advance);
   assign s1_wr_en   = s1_valid_ff && s1_close_ff && s1_advance;

   assign len_cur   = byp_len_hit_ff   ? byp_len_data_ff   : len_rd_data;
   assign joint_cur = byp_joint_hit_ff ? byp_joint_data_ff : joint_rd_data;
   assign len_new   = sat_inc(len_cur);
   assign joint_new = sat_inc(joint_cur);

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_advance) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_op_ff          <= req_op;
         s1_close_ff       <= fr_close;
         s1_length_ff      <= fr_length;
         s1_vowels_ff      <= fr_vowels;
         s1_total_ff       <= fr_total;
         s1_longest_ff     <= fr_longest;
         s1_rl_ok_ff       <= rl_ok;
         s1_rv_ok_ff       <= rv_ok;
         s1_len_addr_ff    <= len_rd_addr;
         s1_joint_addr_ff  <= joint_rd_addr;
         byp_len_hit_ff    <= s1_wr_en && (s1_len_addr_ff == len_rd_addr);
         byp_len_data_ff   <= len_new;
         byp_joint_hit_ff  <= s1_wr_en && (s1_joint_addr_ff == joint_rd_addr);
         byp_joint_data_ff <= joint_new;
      end
   end

   // memory write port: sweep zeroes, otherwise the execute stage writes back
   logic               len_wr_en;
   logic [LW-1:0]      len_wr_addr;
   logic [COUNT_W-1:0] len_wr_data;
   logic               joint_wr_en;
   logic [JW-1:0]      joint_wr_addr;
   logic [COUNT_W-1:0] joint_wr_data;

   always_comb begin
      if (sweep_ff) begin
         len_wr_en     = 1'b1;
         len_wr_addr   = sweep_addr_ff[LW-1:0];
         len_wr_data   = '0;
         joint_wr_en   = 1'b1;
         joint_wr_addr = sweep_addr_ff;
         joint_wr_data = '0;
      end else begin
         len_wr_en     = s1_wr_en;
         len_wr_addr   = s1_len_addr_ff;
         len_wr_data   = len_new;
         joint_wr_en   = s1_wr_en;
         joint_wr_addr = s1_joint_addr_ff;
         joint_wr_data = joint_new;
      end
   end

   uwlvh_ram #(
      .AW (LW),
      .DW (COUNT_W)
   ) u_len_ram (
      .clock   (clock),
      .wr_en   (len_wr_en),
      .wr_addr (len_wr_addr),
      .wr_data (len_wr_data),
      .rd_en   (req_accept),
      .rd_addr (len_rd_addr),
      .rd_data (len_rd_data)
   );

   uwlvh_ram #(
      .AW (JW),
      .DW (COUNT_W)
   ) u_joint_ram (
      .clock   (clock),
      .wr_en   (joint_wr_en),
      .wr_addr (joint_wr_addr),
      .wr_data (joint_wr_data),
      .rd_en   (req_accept),
      .rd_addr (joint_rd_addr),
      .rd_data (joint_rd_data)
   );

   // ------------------------------------------------------------------
   // response register
   // ------------------------------------------------------------------
   logic               out_closed_ff;
   logic [5:0]         out_length_ff;
   logic [5:0]         out_vowels_ff;
   logic [COUNT_W-1:0] out_total_ff;
   logic [5:0]         out_longest_ff;
   logic [COUNT_W-1:0] out_len_count_ff;
   logic [COUNT_W-1:0] out_joint_count_ff;
   logic               s1_is_read;

   assign s1_is_read = (s1_op_ff == OP_READ) && s1_rl_ok_ff;

   always_comb begin
      out_valid_in = out_valid_ff;
      if (s1_valid_ff && s1_advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff && s1_advance) begin
         out_closed_ff      <= s1_close_ff;
         out_length_ff      <= s1_close_ff ? 6'(s1_length_ff) : 6'd0;
         out_vowels_ff      <= s1_close_ff ? 6'(s1_vowels_ff) : 6'd0;
         out_total_ff       <= s1_total_ff;
         out_longest_ff     <= 6'(s1_longest_ff);
         out_len_count_ff   <= s1_is_read ? len_cur : '0;
         out_joint_count_ff <= (s1_is_read && s1_rv_ok_ff) ? joint_cur : '0;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_word_closed   = out_closed_ff;
   assign rsp_closed_length = out_length_ff;
   assign rsp_closed_vowels = out_vowels_ff;
   assign rsp_total_words   = out_total_ff;
   assign rsp_longest_word  = out_longest_ff;
   assign rsp_length_count  = out_len_count_ff;
   assign rsp_joint_count   = out_joint_count_ff;

   // ------------------------------------------------------------------
   // assertions
   // ------------------------------------------------------------------
   a_no_accept_in_sweep : assert property (@(posedge clock) disable iff (reset)
      sweep_ff |-> !req_ready)
      else $error("word accepted during clearing sweep");

   a_no_writeback_in_sweep : assert property (@(posedge clock) disable iff (reset)
      sweep_ff |-> !s1_wr_en)
      else $error("histogram writeback collides with clearing sweep");

   a_close_only_on_push : assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s1_close_ff) |-> (s1_op_ff == OP_PUSH))
      else $error("word closed by a non-push operation");

   a_stage_holds : assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_advance) |=> (s1_valid_ff && $stable(s1_len_addr_ff)))
      else $error("execute stage lost a stalled word");

endmodule

// File: test/utf8_word_length_vowel_histogram_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// utf8_word_length_vowel_histogram_core_tb
// self-checking bench: streams utf-8 text, reads and clears through the
// request channel, predicts every response in a model of its own and
// compares it field by field, with random sender gaps and receiver stalls
// ----------------------------------------------------------------------------
module utf8_word_length_vowel_histogram_core_tb;
   import uwlvh_pkg::*;

   // cycles without any handshake before the run is declared hung; covers
   // the memory sweep after reset or clear plus the long hold-off
   localparam int unsigned STALL_LIMIT  = 20000;
   // length of the forced receiver hold-off
   localparam int unsigned HOLD_CYCLES  = 500;
   // stop point of the random text phase, in words sent
   localparam int unsigned RANDOM_STOP  = 1450;
   // top bin of the length and vowel counts
   localparam logic [5:0]  TOP_BIN      = 6'd63;

   // one expected response
   typedef struct packed {
      logic        closed;
      logic [5:0]  len;
      logic [5:0]  vow;
      logic [31:0] total;
      logic [5:0]  longest;
      logic [31:0] len_cnt;
      logic [31:0] joint_cnt;
   } tally_type;

   logic        clock           = 1'b0;
   logic        reset           = 1'b1;
   logic        req_valid       = 1'b0;
   logic        req_ready;
   logic [1:0]  req_operation   = OP_NONE;
   logic [7:0]  req_data_byte   = 8'h00;
   logic [5:0]  req_read_length = 6'd0;
   logic [5:0]  req_read_vowels = 6'd0;
   logic        rsp_valid;
   logic        rsp_ready       = 1'b0;
   logic        rsp_word_closed;
   logic [5:0]  rsp_closed_length;
   logic [5:0]  rsp_closed_vowels;
   logic [31:0] rsp_total_words;
   logic [5:0]  rsp_longest_word;
   logic [31:0] rsp_length_count;
   logic [31:0] rsp_joint_count;

   // predicted block state
   phase_type   dec_phase;
   logic [5:0]  word_chars;
   logic [5:0]  word_vowels;
   logic [31:0] words_seen;
   logic [5:0]  longest_len;
   logic [31:0] len_bins   [64];
   logic [31:0] joint_bins [64][64];

   // responses still owed by the block, oldest first
   tally_type   tally_q [$];
   tally_type   head;

   int unsigned words_sent     = 0;
   int unsigned responses_seen = 0;
   int unsigned error_count    = 0;
   int unsigned idle_cycles    = 0;

   // sender burst shaping
   int unsigned burst_left     = 0;

   // receiver stall shaping
   logic        hold_request   = 1'b0;
   int unsigned hold_left      = 0;
   int unsigned stretch_left   = 0;
   int unsigned ready_mode     = 0;

   // separators in plain ascii
   logic [7:0]  break_chars [16] = '{8'h09, 8'h0A, 8'h0D, 8'h20, 8'h21, 8'h22,
                                     8'h28, 8'h29, 8'h2C, 8'h2D, 8'h2E, 8'h3A,
                                     8'h3B, 8'h3F, 8'h5B, 8'h5D};

   utf8_word_length_vowel_histogram_core i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_operation     (req_operation),
      .req_data_byte     (req_data_byte),
      .req_read_length   (req_read_length),
      .req_read_vowels   (req_read_vowels),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_word_closed   (rsp_word_closed),
      .rsp_closed_length (rsp_closed_length),
      .rsp_closed_vowels (rsp_closed_vowels),
      .rsp_total_words   (rsp_total_words),
      .rsp_longest_word  (rsp_longest_word),
      .rsp_length_count  (rsp_length_count),
      .rsp_joint_count   (rsp_joint_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // character classes of the predictor
   // ------------------------------------------------------------------------

   // counters stick at all ones
   function automatic logic [31:0] count_up(input logic [31:0] v);
      return (&v) ? v : v + 32'd1;
   endfunction

   // byte after the latin lead: 0x80-0x9f and 0xa0-0xbf mirror each other,
   // so the low five bits pick the folded letter
   function automatic logic [7:0] fold_latin(input logic [7:0] b);
      logic [7:0] r;
      r = b;
      if (b[7:6] == 2'b10) begin
         case (b[4:0])
            5'h00, 5'h01, 5'h02, 5'h03: r = "A";
            5'h08, 5'h09, 5'h0A:        r = "E";
            5'h0C, 5'h0D:               r = "I";
            5'h12, 5'h13, 5'h14, 5'h15: r = "O";
            5'h19, 5'h1A:               r = "U";
            5'h07:                      r = "C";
            default:                    r = b;
         endcase
      end
      return r;
   endfunction

   // last byte of a three-byte punctuation mark, raw when unknown
   function automatic logic [7:0] fold_punct(input logic [7:0] b);
      logic [7:0] r;
      case (b)
         8'h93:        r = "-";
         8'h98, 8'h99: r = "'";
         8'h9C, 8'h9D: r = 8'h22;
         8'hA6:        r = ".";
         default:      r = b;
      endcase
      return r;
   endfunction

   function automatic logic breaks_word(input logic [7:0] ch);
      logic r;
      r = 1'b0;
      foreach (break_chars[i])
         if (break_chars[i] == ch)
            r = 1'b1;
      return r;
   endfunction

   function automatic logic word_letter(input logic [7:0] ch);
      return (ch >= "0" && ch <= "9") || (ch >= "A" && ch <= "Z") ||
             (ch >= "a" && ch <= "z") || ch == "_";
   endfunction

   // setting bit 5 folds upper case onto lower case
   function automatic logic vowel_letter(input logic [7:0] ch);
      logic r;
      case (ch | 8'h20)
         "a", "e", "i", "o", "u": r = 1'b1;
         default:                 r = 1'b0;
      endcase
      return r;
   endfunction

   // random separator from the plain ascii set
   function automatic logic [7:0] pick_break();
      return break_chars[4'($urandom_range(0, 15))];
   endfunction

   // ------------------------------------------------------------------------
   // predictor state handling
   // ------------------------------------------------------------------------

   task automatic wipe_counts;
      foreach (len_bins[i])
         len_bins[i] = '0;
      foreach (joint_bins[i, j])
         joint_bins[i][j] = '0;
      words_seen  = '0;
      longest_len = '0;
   endtask

   task automatic reset_tally;
      dec_phase   = PH_IDLE;
      word_chars  = '0;
      word_vowels = '0;
      wipe_counts();
   endtask

   // advance the predicted state by one accepted word, return its response
   task automatic predict_word(input op_type op, input logic [7:0] b,
                               input logic [5:0] rl, input logic [5:0] rv,
                               output tally_type t);
      logic [7:0] ch;
      logic       have;
      t    = '0;
      ch   = b;
      have = 1'b0;
      case (op)
         OP_PUSH: begin
            case (dec_phase)
               PH_LATIN: begin
                  ch        = fold_latin(b);
                  have      = 1'b1;
                  dec_phase = PH_IDLE;
               end
               PH_MID: begin
                  // middle byte is swallowed whatever it holds
                  dec_phase = PH_LAST;
               end
               PH_LAST: begin
                  ch        = fold_punct(b);
                  have      = 1'b1;
                  dec_phase = PH_IDLE;
               end
               default: begin
                  if (b < ASCII_TOP)
                     have = 1'b1;
                  else if (b == LATIN_LEAD)
                     dec_phase = PH_LATIN;
                  else if (b >= LEAD3_MIN && !(b >= LEAD4_MIN && b <= LEAD4_MAX))
                     dec_phase = PH_MID;
                  // four-byte leads and stray non-ascii bytes vanish
               end
            endcase
            if (have) begin
               if (breaks_word(ch)) begin
                  if (word_chars != '0) begin
                     len_bins[word_chars] = count_up(len_bins[word_chars]);
                     joint_bins[word_vowels][word_chars] =
                        count_up(joint_bins[word_vowels][word_chars]);
                     words_seen = count_up(words_seen);
                     if (word_chars > longest_len)
                        longest_len = word_chars;
                     t.closed    = 1'b1;
                     t.len       = word_chars;
                     t.vow       = word_vowels;
                     word_chars  = '0;
                     word_vowels = '0;
                  end
               end else if (word_letter(ch) && word_chars != TOP_BIN) begin
                  word_chars++;
                  if (vowel_letter(ch))
                     word_vowels++;
               end
            end
         end
         OP_READ: begin
            t.len_cnt   = len_bins[rl];
            t.joint_cnt = joint_bins[rv][rl];
         end
         OP_CLEAR: begin
            // open word and decode phase survive a clear
            wipe_counts();
         end
         default: begin
         end
      endcase
      t.total   = words_seen;
      t.longest = longest_len;
   endtask

   // ------------------------------------------------------------------------
   // request side
   // ------------------------------------------------------------------------

   // offer one word, hold it until accepted, then book its response;
   // entered and left on a rising edge
   task automatic send_word(input op_type op, input logic [7:0] b,
                            input logic [5:0] rl, input logic [5:0] rv);
      tally_type   want;
      int unsigned gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         // a third of the bursts follow the previous one without a break
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid       <= 1'b1;
      req_operation   <= op;
      req_data_byte   <= b;
      req_read_length <= rl;
      req_read_vowels <= rv;
      do
         @(posedge clock);
      while (req_ready !== 1'b1);
      predict_word(op, b, rl, rv, want);
      tally_q.push_back(want);
      words_sent++;
   endtask

   task automatic push_byte(input logic [7:0] b);
      send_word(OP_PUSH, b, 6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)));
   endtask

   // stop offering until every booked response is back
   task automatic wait_drained;
      req_valid <= 1'b0;
      do
         @(posedge clock);
      while (tally_q.size() != 0);
   endtask

   // one character of a word, sometimes one that the block skips
   task automatic push_letter;
      case ($urandom_range(0, 9))
         0:       push_byte(8'("a" + $urandom_range(0, 25)));
         1:       push_byte(8'("A" + $urandom_range(0, 25)));
         2, 3: begin
            case ($urandom_range(0, 4))
               0:       push_byte("a");
               1:       push_byte("E");
               2:       push_byte("i");
               3:       push_byte("O");
               default: push_byte("u");
            endcase
         end
         4:       push_byte(8'("0" + $urandom_range(0, 9)));
         5:       push_byte("_");
         6, 7: begin
            // accented letter, now and then an unknown or ascii follower
            push_byte(LATIN_LEAD);
            if ($urandom_range(0, 5) == 0)
               push_byte(8'($urandom_range(0, 255)));
            else
               push_byte(8'(8'h80 + $urandom_range(0, 63)));
         end
         8: begin
            // apostrophes, plain or curly, are ignored
            if ($urandom_range(0, 1) != 0) begin
               push_byte("'");
            end else begin
               push_byte(8'hE2);
               push_byte(8'h80);
               push_byte(8'(8'h98 + $urandom_range(0, 1)));
            end
         end
         default: push_byte(8'("b" + $urandom_range(0, 2)));
      endcase
   endtask

   // something that ends a word
   task automatic push_break;
      case ($urandom_range(0, 5))
         0, 1, 2: push_byte(pick_break());
         3: begin
            push_byte(8'hE2);
            push_byte(8'h80);
            case ($urandom_range(0, 3))
               0:       push_byte(8'h93);
               1:       push_byte(8'h9C);
               2:       push_byte(8'h9D);
               default: push_byte(8'hA6);
            endcase
         end
         4: begin
            // three-byte lead of any kind with a raw separator at the end
            push_byte(($urandom_range(0, 1) != 0) ? 8'(8'hE0 + $urandom_range(0, 15))
                                                  : 8'(8'hF8 + $urandom_range(0, 7)));
            push_byte(8'($urandom_range(0, 255)));
            push_byte(pick_break());
         end
         default: begin
            // latin lead swallows the next byte, which passes on raw
            push_byte(LATIN_LEAD);
            push_byte(pick_break());
         end
      endcase
   endtask

   // ------------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------------

   task automatic test_directed;
      send_word(OP_READ, 8'h00, 6'd0, 6'd0);
      // accented letter inside a word, space closes it
      push_byte("A");
      push_byte(LATIN_LEAD);
      push_byte(8'hA7);
      push_byte("e");
      push_byte(8'h20);
      // three-byte dash closes a word
      push_byte("9");
      push_byte(8'hE2);
      push_byte(8'h80);
      push_byte(8'h93);
      // four-byte lead and stray non-ascii byte both vanish
      push_byte("o");
      push_byte(8'hF0);
      push_byte(8'h85);
      push_byte(8'h09);
      // f8 lead acts as a three-byte lead, unknown final byte passes raw
      push_byte("x");
      push_byte(8'hF8);
      push_byte(8'h00);
      push_byte(8'h2E);
      // read, clear and unused operation between a lead and its follower
      push_byte(LATIN_LEAD);
      send_word(OP_READ, 8'hFF, 6'd1, 6'd1);
      send_word(OP_CLEAR, 8'h55, 6'd2, 6'd2);
      send_word(OP_NONE, 8'hFF, 6'd63, 6'd63);
      push_byte(8'h89);
      // three-byte period closes the word built across the clear
      push_byte(8'hE2);
      push_byte(8'h80);
      push_byte(8'hA6);
      send_word(OP_READ, 8'hAA, 6'd1, 6'd1);
   endtask

   // counts stick at the top bin
   task automatic test_long_words;
      repeat (70) push_byte("a");
      push_byte(8'h20);
      repeat (63) push_byte("B");
      push_byte("?");
      repeat (62) push_letter();
      push_byte(",");
      send_word(OP_READ, 8'h00, 6'd63, 6'd63);
      send_word(OP_READ, 8'hFF, 6'd63, 6'd0);
   endtask

   // mostly well-formed text, with reads, noise and broken sequences mixed in
   task automatic test_random_text;
      int unsigned pick;
      int unsigned n;
      logic [5:0]  rl;
      while (words_sent < RANDOM_STOP) begin
         pick = $urandom_range(0, 99);
         if ($urandom_range(0, 299) == 0)
            send_word(OP_CLEAR, 8'($urandom_range(0, 255)), 6'($urandom_range(0, 63)),
                      6'($urandom_range(0, 63)));
         if (pick < 60) begin
            n = ($urandom_range(0, 19) == 0) ? $urandom_range(13, 70)
                                             : $urandom_range(1, 10);
            repeat (n) push_letter();
            push_break();
         end else if (pick < 74) begin
            // reads lean toward the bins that fill up
            rl = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63))
                                             : 6'($urandom_range(1, 10));
            send_word(OP_READ, 8'($urandom_range(0, 255)), rl,
                      ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63))
                                                  : 6'($urandom_range(0, rl)));
         end else if (pick < 82) begin
            // lead byte cut into by another operation
            case ($urandom_range(0, 2))
               0:       push_byte(LATIN_LEAD);
               1:       push_byte(8'(8'hE0 + $urandom_range(0, 15)));
               default: push_byte(8'(8'hF8 + $urandom_range(0, 7)));
            endcase
            send_word(($urandom_range(0, 1) != 0) ? OP_READ : OP_NONE,
                      8'($urandom_range(0, 255)), 6'($urandom_range(0, 63)),
                      6'($urandom_range(0, 63)));
            push_byte(8'($urandom_range(0, 255)));
         end else if (pick < 90) begin
            repeat ($urandom_range(1, 3)) push_byte(8'($urandom_range(0, 255)));
         end else if (pick < 94) begin
            send_word(OP_NONE, 8'($urandom_range(0, 255)), 6'($urandom_range(0, 63)),
                      6'($urandom_range(0, 63)));
         end else begin
            // separator with no open word
            push_break();
         end
      end
   endtask

   // receiver holds off while text keeps coming, then a full drain pause
   task automatic test_stalled_output;
      int unsigned k;
      hold_request = 1'b1;
      for (k = 0; k < 12; k++) begin
         repeat ($urandom_range(1, 6)) push_letter();
         push_break();
      end
      wait_drained();
      send_word(OP_READ, 8'h00, 6'd3, 6'd1);
      send_word(OP_CLEAR, 8'hFF, 6'd0, 6'd0);
      repeat (4) push_letter();
      push_break();
      send_word(OP_READ, 8'h00, 6'd4, 6'd2);
   endtask

   // ------------------------------------------------------------------------
   // response side
   // ------------------------------------------------------------------------

   // receiver: random stretches of always ready, coin flips, sparse and
   // periodic acceptance, or a forced hold-off when asked for
   always @(posedge clock) begin
      if (hold_request) begin
         if (hold_left == 0)
            hold_left = HOLD_CYCLES;
         hold_left--;
         if (hold_left == 0)
            hold_request = 1'b0;
         rsp_ready <= 1'b0;
      end else begin
         if (stretch_left == 0) begin
            stretch_left = $urandom_range(16, 160);
            ready_mode   = $urandom_range(0, 3);
         end
         stretch_left--;
         case (ready_mode)
            0:       rsp_ready <= 1'b1;
            1:       rsp_ready <= ($urandom_range(0, 1) != 0);
            2:       rsp_ready <= ($urandom_range(0, 3) == 0);
            default: rsp_ready <= (stretch_left % 3 != 0);
         endcase
      end
   end

   task automatic log_mismatch(input string msg);
      error_count++;
      $display("mismatch at response %0d: %s", responses_seen, msg);
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want)
         log_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
   endtask

   // every accepted response against the oldest booked one
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         if (tally_q.size() == 0) begin
            log_mismatch("response with no word outstanding");
         end else begin
            head = tally_q.pop_front();
            check_field("word_closed",   32'(rsp_word_closed),   32'(head.closed));
            check_field("closed_length", 32'(rsp_closed_length), 32'(head.len));
            check_field("closed_vowels", 32'(rsp_closed_vowels), 32'(head.vow));
            check_field("total_words",   rsp_total_words,        head.total);
            check_field("longest_word",  32'(rsp_longest_word),  32'(head.longest));
            check_field("length_count",  rsp_length_count,       head.len_cnt);
            check_field("joint_count",   rsp_joint_count,        head.joint_cnt);
         end
         responses_seen++;
      end
   end

   // watchdog on cycles with no handshake at all
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready === 1'b1) ||
          (rsp_valid === 1'b1 && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------------
   // sequence
   // ------------------------------------------------------------------------
   initial begin
      reset_tally();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_long_words();
      test_random_text();
      test_stalled_output();
      wait_drained();
      // room for any stray response after the last one
      repeat (8) @(posedge clock);
      if (error_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
